FILE: sv/dideo_pkg.sv
// Shared constants and types for the depth and region-id outline core.
`timescale 1ns / 1ps
`default_nettype none

package dideo_pkg;

    localparam int FRAME_WIDTH_BITS  = 12;
    localparam int FRAME_HEIGHT_BITS = 13;
    localparam int THRESH_BITS       = 16;
    localparam int ROW_BITS          = 12;
    localparam int COLOR_BITS        = 32;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS     = 16;

    localparam logic [FRAME_HEIGHT_BITS-1:0] HEIGHT_LIMIT = 13'd4096;
    localparam logic [COLOR_BITS-1:0]        BLACK_OPAQUE = 32'hff00_0000;

    localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;
    // 0.8 in unsigned Q8.8
    localparam logic [THRESH_BITS-1:0]       THRESHOLD_RST    = 16'd204;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_WIDTH     = 2'd0,
        REG_FRAME_HEIGHT    = 2'd1,
        REG_DEPTH_THRESHOLD = 2'd2,
        REG_OUTLINE_ENABLE  = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

FILE: sv/depth_id_edge_outline_core.sv
// Top level of the depth and region-id outline core with its line store.
`timescale 1ns / 1ps
`default_nettype none

// Raster-order outline effect. Pixels (region id, Q8.8 depth, ARGB color)
// enter on the s_ channel with valid/ready; one result per pixel leaves on
// the m_ channel: the color, or opaque black for an edge pixel while outline
// is enabled, plus an is_edge flag.
// A pixel is an edge when its left neighbor (column > 0) or the pixel above
// (row > 0) carries another id or a depth differing by more than the
// threshold. Column and row counters wrap at the configured frame size.
// An accepted transaction passes the middle stage and the output register
// on its way to m_. Throughput: one pixel per cycle while the receiver does
// not stall, set by the single read-first port of the line store, which reads
// the row above and writes the new pixel in the same cycle the transaction is accepted.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata, write while idle only.
// Reset (aresetn low, synchronous) clears counters, the left neighbor, the
// pipeline valids and restores register defaults; the line store is not
// cleared and needs no clearing pass, each entry is written on the row above
// before it is read.
// When the receiver stalls, the output register holds, the middle stage
// holds behind it, and s_ready drops once both are full.
module depth_id_edge_outline_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int ID_BITS    = 8,
    parameter int DEPTH_BITS = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration
    input  wire logic                               cfg_wr_en,
    input  wire logic [dideo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [dideo_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    // pixel input
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [ID_BITS-1:0]                 s_region_id,
    input  wire logic [DEPTH_BITS-1:0]              s_pixel_depth,
    input  wire logic [dideo_pkg::COLOR_BITS-1:0]   s_pixel_color,
    // result output
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [dideo_pkg::COLOR_BITS-1:0]        m_color_out,
    output logic                                    m_is_edge
);
    import dideo_pkg::*;

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int CMPW    = (CW + 1 > FRAME_WIDTH_BITS) ? CW + 1 : FRAME_WIDTH_BITS;
    localparam int ENTRY_W = ID_BITS + DEPTH_BITS;
    localparam int TW      = (DEPTH_BITS > THRESH_BITS) ? DEPTH_BITS : THRESH_BITS;

    // configuration registers
    logic [FRAME_WIDTH_BITS-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_BITS-1:0] frame_height_reg;
    logic [THRESH_BITS-1:0]       depth_threshold_reg;
    logic                         outline_enable_reg;

    // position and left neighbor
    logic [CW-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [ENTRY_W-1:0]  left_reg;

    // line store
    logic [ENTRY_W-1:0] line_mem [MAX_WIDTH];

    // middle stage
    logic                  s1_valid_reg;
    logic [ENTRY_W-1:0]    s1_cur_reg;
    logic [ENTRY_W-1:0]    s1_left_reg;
    logic [ENTRY_W-1:0]    s1_above_reg;
    logic [COLOR_BITS-1:0] s1_color_reg;
    logic                  s1_col_nz_reg;
    logic                  s1_row_nz_reg;

    // output register
    logic                  m_valid_reg;
    logic [COLOR_BITS-1:0] m_color_reg;
    logic                  m_is_edge_reg;

    logic               accept;
    logic               out_free;
    logic               s1_move;
    logic [ENTRY_W-1:0] cur_entry;
    logic [CMPW-1:0]    col_inc;
    logic [FRAME_HEIGHT_BITS-1:0] row_inc;
    logic               col_wrap;
    logic               row_wrap;
    logic               edge_left;
    logic               edge_above;
    logic               edge_comb;

    // id mismatch or absolute depth difference above the threshold
    function automatic logic cell_differs(input logic [ENTRY_W-1:0] a,
                                          input logic [ENTRY_W-1:0] b,
                                          input logic [THRESH_BITS-1:0] thr);
        logic [DEPTH_BITS-1:0] da;
        logic [DEPTH_BITS-1:0] db;
        logic [DEPTH_BITS-1:0] diff;
        da   = a[DEPTH_BITS-1:0];
        db   = b[DEPTH_BITS-1:0];
        diff = (da >= db) ? (da - db) : (db - da);
        return (a[ENTRY_W-1:DEPTH_BITS] != b[ENTRY_W-1:DEPTH_BITS]) ||
               (TW'(diff) > TW'(thr));
    endfunction

    // Handshake: output register frees when empty or taken; the middle stage
    // moves forward when it holds a pixel and the output is free.
    assign out_free = !m_valid_reg || m_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    assign cur_entry = {s_region_id, s_pixel_depth};

    // Advance the counters; width 0 and height 0 act as 1, large values clamp.
    always_comb begin
        col_inc  = CMPW'(col_reg) + CMPW'(1);
        row_inc  = FRAME_HEIGHT_BITS'(row_reg) + FRAME_HEIGHT_BITS'(1);
        col_wrap = (col_inc >= CMPW'(frame_width_reg)) ||
                   (col_inc >= CMPW'(MAX_WIDTH));
        row_wrap = (row_inc >= frame_height_reg) || (row_inc >= HEIGHT_LIMIT);
        col_next = col_wrap ? '0 : col_inc[CW-1:0];
        row_next = row_reg;
        if (col_wrap) begin
            row_next = row_wrap ? '0 : row_inc[ROW_BITS-1:0];
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg     <= FRAME_WIDTH_RST;
            frame_height_reg    <= FRAME_HEIGHT_RST;
            depth_threshold_reg <= THRESHOLD_RST;
            outline_enable_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:     frame_width_reg     <= cfg_wdata[FRAME_WIDTH_BITS-1:0];
                REG_FRAME_HEIGHT:    frame_height_reg    <= cfg_wdata[FRAME_HEIGHT_BITS-1:0];
                REG_DEPTH_THRESHOLD: depth_threshold_reg <= cfg_wdata[THRESH_BITS-1:0];
                REG_OUTLINE_ENABLE:  outline_enable_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Position counters and left neighbor: advance on every accepted pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end else if (accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= cur_entry;
        end
    end

    // Line store, read-first: fetch the pixel above, then replace it
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_above_reg     <= line_mem[col_reg];
            line_mem[col_reg] <= cur_entry;
        end
    end

    // Middle stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cur_reg    <= cur_entry;
            s1_left_reg   <= left_reg;
            s1_color_reg  <= s_pixel_color;
            s1_col_nz_reg <= (col_reg != '0);
            s1_row_nz_reg <= (row_reg != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    // Edge decision
    always_comb begin
        edge_left  = s1_col_nz_reg &&
                     cell_differs(s1_left_reg, s1_cur_reg, depth_threshold_reg);
        edge_above = s1_row_nz_reg &&
                     cell_differs(s1_above_reg, s1_cur_reg, depth_threshold_reg);
        edge_comb  = edge_left || edge_above;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_is_edge_reg <= edge_comb;
            m_color_reg   <= (edge_comb && outline_enable_reg) ? BLACK_OPAQUE
                                                               : s1_color_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_color_out = m_color_reg;
    assign m_is_edge   = m_is_edge_reg;

    // The first pixel of a frame has no neighbors and is never an edge
    a_origin_no_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_col_nz_reg && !s1_row_nz_reg |-> !edge_comb)
        else $error("origin pixel flagged as edge");

    // Never accept over a middle-stage pixel that cannot move on
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s1_valid_reg |-> out_free)
        else $error("middle stage overwritten while stalled");

    // A pixel leaving the middle stage shows up as a result
    a_move_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_move |=> m_valid_reg)
        else $error("result lost between stages");

    // An enabled edge result is opaque black
    a_black_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_is_edge_reg && outline_enable_reg |->
            m_color_reg == BLACK_OPAQUE)
        else $error("edge pixel not painted black");

endmodule

`default_nettype wire
